// ===== rtl/ssel_pkg.sv =====
package ssel_pkg;

  localparam int unsigned NodesDef = 256;
  localparam int unsigned CandDef  = 16;
  localparam int unsigned LenW     = 14;
  localparam int unsigned RangeW   = 22;
  localparam int unsigned TotalW   = 30;
  localparam int unsigned CfgW     = 22;

  localparam logic [RangeW-1:0] NoHouseNearest = 22'h3f3f3f;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_EVAL  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] REG_HOUSE_COUNT = 2'd0;
  localparam logic [1:0] REG_CAND_COUNT  = 2'd1;
  localparam logic [1:0] REG_RANGE       = 2'd2;

  typedef struct packed {
    logic [7:0]        house_count;
    logic [4:0]        candidate_count;
    logic [RangeW-1:0] service_range;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [4:0]        chosen_candidate;
    logic [RangeW-1:0] nearest_distance;
    logic [TotalW-1:0] total_distance;
  } res_t;

endpackage

// ===== rtl/ssel_ram.sv =====
module ssel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ssel_ctrl.sv =====
module ssel_ctrl #(
  parameter int unsigned Nodes      = 256,
  parameter int unsigned Candidates = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    node_a_i,
  input  logic [7:0]    node_b_i,
  input  logic [13:0]   edge_length_i,
  input  ssel_pkg::cfg_t cfg_i,
  output ssel_pkg::res_t res_o,
  output logic          done_o
);
  import ssel_pkg::*;

  localparam int unsigned NW = $clog2(Nodes);
  localparam int unsigned AW = 2 * NW;
  localparam int unsigned DW = NW + LenW;
  localparam int unsigned CW = $clog2(Candidates + 1);
  localparam int unsigned EW = LenW + 1;
  localparam int unsigned MW = DW + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_ADDCK = 4'd2;
  localparam logic [3:0] S_ADDW2 = 4'd3;
  localparam logic [3:0] S_CAND  = 4'd4;
  localparam logic [3:0] S_INIT  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_RELAX = 4'd7;
  localparam logic [3:0] S_HRD   = 4'd8;
  localparam logic [3:0] S_HCK   = 4'd9;
  localparam logic [3:0] S_CMP   = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [NW:0]       sw_q, sw_d;
  logic [NW-1:0]     src_q, src_d, pick_q, pick_d;
  logic [DW-1:0]     pd_q, pd_d;
  logic              have_q, have_d;
  logic [CW-1:0]     c_q, c_d, bs_q, bs_d;
  logic [7:0]        h_q, h_d;
  logic [NW-1:0]     ea_q, ea_d, eb_q, eb_d;
  logic [LenW-1:0]   elen_q, elen_d;
  logic [RangeW-1:0] near_q, near_d, bn_q, bn_d;
  logic [TotalW-1:0] tot_q, tot_d, bt_q, bt_d;
  res_t              res_q, res_d;
  logic              done_q, done_d;

  logic              adj_we;
  logic [AW-1:0]     adj_waddr, adj_raddr;
  logic [EW-1:0]     adj_wdata, adj_rdata;
  logic              dist_we;
  logic [NW-1:0]     dist_waddr, dist_raddr;
  logic [MW-1:0]     dist_wdata, dist_rdata;

  ssel_ram #(.Width(EW), .Depth(Nodes * Nodes)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  // distance word: {visited, unreached, distance}
  ssel_ram #(.Width(MW), .Depth(Nodes)) u_dist (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr), .rdata_o(dist_rdata)
  );

  logic          w_vis, w_unr;
  logic [DW-1:0] w_d;
  logic [NW-1:0] idx;
  logic [DW:0]   nd;
  logic          imp, pick_ok, ends_ok;
  logic [31:0]   node;
  logic [30:0]   sum;
  logic [RangeW-1:0] d22;

  assign w_vis = dist_rdata[MW-1];
  assign w_unr = dist_rdata[MW-2];
  assign w_d   = dist_rdata[DW-1:0];
  assign idx   = NW'(sw_q - (NW+1)'(1));
  assign nd    = {1'b0, pd_q} + (DW+1)'(adj_rdata[LenW-1:0]);
  assign imp   = adj_rdata[LenW] && (w_unr || nd < {1'b0, w_d});
  assign pick_ok = !w_vis && !w_unr && (!have_q || w_d < pd_q);
  assign ends_ok = (32'(node_a_i) < Nodes) && (32'(node_b_i) < Nodes);
  assign node  = 32'(cfg_i.house_count) + 32'(c_q);
  assign d22   = RangeW'(w_d);
  assign sum   = {1'b0, tot_q} + 31'(d22);

  always_comb begin
    state_d = state_q; clr_d = clr_q; sw_d = sw_q; src_d = src_q; pick_d = pick_q;
    pd_d = pd_q; have_d = have_q; c_d = c_q; bs_d = bs_q; h_d = h_q;
    ea_d = ea_q; eb_d = eb_q; elen_d = elen_q; near_d = near_q; bn_d = bn_q;
    tot_d = tot_q; bt_d = bt_q; res_d = res_q; done_d = 1'b0;
    adj_we = 1'b0; adj_waddr = clr_q; adj_wdata = '0;
    adj_raddr = {pick_q, sw_q[NW-1:0]};
    dist_we = 1'b0; dist_waddr = idx; dist_wdata = '0;
    dist_raddr = sw_q[NW-1:0];

    unique case (state_q)
      S_IDLE: begin
        adj_raddr = {NW'(node_a_i), NW'(node_b_i)};
        if (start) begin
          ea_d = NW'(node_a_i);
          eb_d = NW'(node_b_i);
          elen_d = edge_length_i;
          case (kind_i)
            KIND_ADD: if (ends_ok) state_d = S_ADDCK;
            KIND_CLEAR: begin
              clr_d = '0;
              state_d = S_CLR;
            end
            KIND_EVAL: begin
              bs_d = '0; bn_d = '0; bt_d = '0;
              c_d = (32'(cfg_i.candidate_count) > Candidates) ? CW'(Candidates)
                                                              : CW'(cfg_i.candidate_count);
              state_d = S_CAND;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        adj_we = 1'b1;
        clr_d = clr_q + AW'(1);
        if (&clr_q) state_d = S_IDLE;
      end
      S_ADDCK: begin
        adj_waddr = {ea_q, eb_q};
        adj_wdata = {1'b1, elen_q};
        if (!adj_rdata[LenW] || elen_q < adj_rdata[LenW-1:0]) begin
          adj_we = 1'b1;
          state_d = S_ADDW2;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ADDW2: begin
        adj_we = 1'b1;
        adj_waddr = {eb_q, ea_q};
        adj_wdata = {1'b1, elen_q};
        state_d = S_IDLE;
      end
      S_CAND: begin
        if (c_q == '0) begin
          res_d.found = (bs_q != '0);
          res_d.chosen_candidate = 5'(bs_q);
          res_d.nearest_distance = bn_q;
          res_d.total_distance = bt_q;
          done_d = 1'b1;
          state_d = S_IDLE;
        end else if (node >= Nodes) begin
          c_d = c_q - CW'(1);
        end else begin
          src_d = NW'(node);
          sw_d = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        dist_we = 1'b1;
        dist_waddr = sw_q[NW-1:0];
        dist_wdata = {1'b0, sw_q[NW-1:0] != src_q, DW'(0)};
        sw_d = sw_q + (NW+1)'(1);
        if (sw_q[NW-1:0] == NW'(Nodes - 1)) begin
          sw_d = '0;
          have_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // min search: data of entry sw-1 arrives while sw is read
        if (sw_q != '0 && pick_ok) begin
          pick_d = idx;
          pd_d = w_d;
          have_d = 1'b1;
        end
        sw_d = sw_q + (NW+1)'(1);
        if (32'(sw_q) == Nodes) begin
          sw_d = '0;
          if (have_d) begin
            state_d = S_RELAX;
          end else if (cfg_i.house_count == '0) begin
            near_d = NoHouseNearest;
            tot_d = '0;
            state_d = S_CMP;
          end else begin
            near_d = NoHouseNearest;
            tot_d = '0;
            h_d = 8'd1;
            state_d = S_HRD;
          end
        end
      end
      S_RELAX: begin
        if (sw_q != '0) begin
          dist_we = 1'b1;
          dist_wdata = {w_vis | (idx == pick_q), imp ? 1'b0 : w_unr,
                        imp ? nd[DW-1:0] : w_d};
        end
        sw_d = sw_q + (NW+1)'(1);
        if (32'(sw_q) == Nodes) begin
          sw_d = '0;
          have_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_HRD: begin
        dist_raddr = NW'(h_q);
        if (32'(h_q) >= Nodes) begin
          c_d = c_q - CW'(1);
          state_d = S_CAND;
        end else begin
          state_d = S_HCK;
        end
      end
      S_HCK: begin
        if (w_unr || 32'(w_d) > 32'(cfg_i.service_range)) begin
          c_d = c_q - CW'(1);
          state_d = S_CAND;
        end else begin
          if (d22 < near_q) near_d = d22;
          tot_d = sum[30] ? '1 : sum[TotalW-1:0];
          if (h_q == cfg_i.house_count) begin
            state_d = S_CMP;
          end else begin
            h_d = h_q + 8'd1;
            state_d = S_HRD;
          end
        end
      end
      S_CMP: begin
        if (bs_q == '0 || near_q > bn_q || (near_q == bn_q && tot_q <= bt_q)) begin
          bs_d = c_q;
          bn_d = near_q;
          bt_d = tot_q;
        end
        c_d = c_q - CW'(1);
        state_d = S_CAND;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      done_q <= 1'b0;
      bs_q <= '0;
      bn_q <= '0;
      bt_q <= '0;
      c_q <= '0;
      res_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      done_q <= done_d;
      bs_q <= bs_d;
      bn_q <= bn_d;
      bt_q <= bt_d;
      c_q <= c_d;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_q <= sw_d; src_q <= src_d; pick_q <= pick_d; pd_q <= pd_d; have_q <= have_d;
    h_q <= h_d; ea_q <= ea_d; eb_q <= eb_d; elen_q <= elen_d;
    near_q <= near_d; tot_q <= tot_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== rtl/shortest_path_station_selector.sv =====
// Shortest-path station selector.
// Command channel: an item (kind_i, node_a_i, node_b_i, edge_length_i) is
// taken at a clock edge with start high and busy low. An add item first reads
// the adjacency memory, then writes one entry per direction if the edge is new
// or shorter. A clear item rewrites the NODES*NODES adjacency memory, one
// entry a cycle (65536 entries at the default size).
// An evaluate item runs a search from each candidate: it sets up the distance
// memory, alternates minimum scans and relax passes over all NODES entries
// until no unvisited reachable node is left, then checks the houses against the
// service range.
// The result beat follows the last candidate: done_o is high for exactly one
// cycle with found_o, chosen_candidate_o, nearest_distance_o and
// total_distance_o; the receiver cannot stall it.
// Add and clear items produce no beat.
// After reset the block runs the same adjacency clearing pass and holds busy
// high until it completes. Config writes (cfg_we_i, cfg_idx_i, cfg_data_i)
// are taken at any edge and are meant to change only while idle.
module shortest_path_station_selector #(
  parameter int unsigned NODES      = ssel_pkg::NodesDef,
  parameter int unsigned CANDIDATES = ssel_pkg::CandDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic [7:0]                   node_a_i,
  input  logic [7:0]                   node_b_i,
  input  logic [13:0]                  edge_length_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ssel_pkg::CfgW-1:0]    cfg_data_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic [4:0]                   chosen_candidate_o,
  output logic [ssel_pkg::RangeW-1:0]  nearest_distance_o,
  output logic [ssel_pkg::TotalW-1:0]  total_distance_o
);
  import ssel_pkg::*;

  cfg_t cfg_q;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.house_count <= 8'd1;
      cfg_q.candidate_count <= 5'd1;
      cfg_q.service_range <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOUSE_COUNT: cfg_q.house_count <= cfg_data_i[7:0];
        REG_CAND_COUNT:  cfg_q.candidate_count <= cfg_data_i[4:0];
        REG_RANGE:       cfg_q.service_range <= cfg_data_i[RangeW-1:0];
        default: ;
      endcase
    end
  end

  ssel_ctrl #(.Nodes(NODES), .Candidates(CANDIDATES)) u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .node_a_i, .node_b_i, .edge_length_i,
    .cfg_i(cfg_q), .res_o(res), .done_o
  );

  assign found_o            = res.found;
  assign chosen_candidate_o = res.chosen_candidate;
  assign nearest_distance_o = res.nearest_distance;
  assign total_distance_o   = res.total_distance;

endmodule

// ===== rtl/ssel_checker.sv =====
module ssel_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic                        found_o,
  input logic [4:0]                  chosen_candidate_o,
  input logic [ssel_pkg::RangeW-1:0] nearest_distance_o,
  input logic [ssel_pkg::TotalW-1:0] total_distance_o
);

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |->
      (chosen_candidate_o == 5'd0 && nearest_distance_o == '0 && total_distance_o == '0))
    else $error("empty result carries nonzero fields");

  a_found_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> chosen_candidate_o != 5'd0)
    else $error("found result without candidate");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat repeated");

  a_accept_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result beat right after an accept");

endmodule

bind shortest_path_station_selector ssel_checker u_ssel_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ssel_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [13:0] len;
  } cmd_t;

  localparam int unsigned NumNodes  = NodesDef;
  localparam int unsigned UnReached = 32'hffffffff;
  localparam int unsigned TotalMax  = 32'h3fffffff;
  localparam int unsigned CycleCap  = 12_000_000;
  localparam logic [1:0]  KindSpare = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        kind_i = KIND_ADD;
  logic [7:0]        node_a_i = '0;
  logic [7:0]        node_b_i = '0;
  logic [13:0]       edge_length_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = REG_HOUSE_COUNT;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              done_o;
  logic              found_o;
  logic [4:0]        chosen_candidate_o;
  logic [RangeW-1:0] nearest_distance_o;
  logic [TotalW-1:0] total_distance_o;

  shortest_path_station_selector uut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .node_a_i, .node_b_i, .edge_length_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .found_o, .chosen_candidate_o,
    .nearest_distance_o, .total_distance_o
  );

  // graph mirror: bit 14 marks a present edge
  logic [14:0] link_len [NumNodes][NumNodes];
  int unsigned m_houses = 1, m_cands = 1, m_range = 0;

  cmd_t pending[$];
  res_t station_picks[$];
  int unsigned errors = 0, cycles = 0, beats_in = 0, picks_seen = 0, picks_found = 0;
  logic acc = 1'b0;
  int unsigned burst_left = 5, gap_left = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic res_t pick_station();
    int unsigned hop_len [NumNodes];
    bit seen [NumNodes];
    int unsigned cnt, node, nearest, total, pd, pick, nd;
    int unsigned bn, bt, bs;
    bit ok;
    res_t r;
    bn = 0; bt = 0; bs = 0;
    cnt = (m_cands > CandDef) ? CandDef : m_cands;
    for (int c = cnt; c >= 1; c--) begin
      node = m_houses + c;
      if (node >= NumNodes) continue;
      for (int i = 0; i < NumNodes; i++) begin
        hop_len[i] = UnReached;
        seen[i] = 1'b0;
      end
      hop_len[node] = 0;
      forever begin
        pick = NumNodes;
        pd = UnReached;
        for (int i = 0; i < NumNodes; i++)
          if (!seen[i] && hop_len[i] != UnReached &&
              (pick == NumNodes || hop_len[i] < pd)) begin
            pick = i;
            pd = hop_len[i];
          end
        if (pick == NumNodes) break;
        seen[pick] = 1'b1;
        for (int v = 0; v < NumNodes; v++)
          if (link_len[pick][v][14]) begin
            nd = pd + link_len[pick][v][13:0];
            if (nd < hop_len[v]) hop_len[v] = nd;
          end
      end
      nearest = NoHouseNearest;
      total = 0;
      ok = 1'b1;
      for (int h = 1; h <= m_houses; h++) begin
        if (h >= NumNodes || hop_len[h] == UnReached || hop_len[h] > m_range) begin
          ok = 1'b0;
          break;
        end
        if (hop_len[h] < nearest) nearest = hop_len[h];
        total = (total > TotalMax - hop_len[h]) ? TotalMax : total + hop_len[h];
      end
      if (!ok) continue;
      if (bs == 0 || nearest > bn || (nearest == bn && total <= bt)) begin
        bn = nearest;
        bt = total;
        bs = c;
      end
    end
    r = '0;
    if (bs != 0) begin
      r.found = 1'b1;
      r.chosen_candidate = bs[4:0];
      r.nearest_distance = bn[RangeW-1:0];
      r.total_distance = bt[TotalW-1:0];
    end
    return r;
  endfunction

  // monitor and prediction
  always @(posedge clk_i) begin
    res_t want;
    cycles++;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_ni) begin
      acc <= start && !busy;
      if (start && !busy) begin
        beats_in++;
        case (kind_i)
          KIND_ADD: begin
            if (!link_len[node_a_i][node_b_i][14] ||
                edge_length_i < link_len[node_a_i][node_b_i][13:0]) begin
              link_len[node_a_i][node_b_i] = {1'b1, edge_length_i};
              link_len[node_b_i][node_a_i] = {1'b1, edge_length_i};
            end
          end
          KIND_EVAL: station_picks.insert(station_picks.size(), pick_station());
          KIND_CLEAR: begin
            foreach (link_len[i, j]) link_len[i][j] = '0;
          end
          default: ;
        endcase
      end
      if (done_o) begin
        picks_seen++;
        if (station_picks.size() == 0) report("result beat with nothing expected");
        else begin
          want = station_picks.pop_front();
          if (want.found) picks_found++;
          if (found_o !== want.found)
            report($sformatf("found %b want %b", found_o, want.found));
          if (chosen_candidate_o !== want.chosen_candidate)
            report($sformatf("candidate %0d want %0d", chosen_candidate_o,
                             want.chosen_candidate));
          if (nearest_distance_o !== want.nearest_distance)
            report($sformatf("nearest %0d want %0d", nearest_distance_o,
                             want.nearest_distance));
          if (total_distance_o !== want.total_distance)
            report($sformatf("total %0d want %0d", total_distance_o, want.total_distance));
        end
      end
    end
  end

  // command driver: bursts with random gaps
  always @(negedge clk_i) begin
    cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !acc) begin
      // beat still waiting
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending.size() > 0) begin
      nxt = pending.pop_front();
      kind_i <= nxt.kind;
      node_a_i <= nxt.a;
      node_b_i <= nxt.b;
      edge_length_i <= nxt.len;
      start <= 1'b1;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_cmd(input logic [1:0] k, input int a, input int b, input int len);
    cmd_t c;
    c.kind = k;
    c.a = a[7:0];
    c.b = b[7:0];
    c.len = len[13:0];
    pending.insert(pending.size(), c);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgW-1:0];
    case (idx)
      REG_HOUSE_COUNT: m_houses = val & 32'hff;
      REG_CAND_COUNT:  m_cands = val & 32'h1f;
      REG_RANGE:       m_range = val & 32'h3fffff;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned hc, input int unsigned cc, input int unsigned rng);
    write_reg(REG_HOUSE_COUNT, hc);
    write_reg(REG_CAND_COUNT, cc);
    write_reg(REG_RANGE, rng);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending.size() != 0 || start || busy || station_picks.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // edges mostly inside a small cluster so searches stay short
  task automatic random_phase(input bit with_clear);
    int unsigned hc, cc, rng, span, n, r;
    hc = $urandom_range(1, 6);
    cc = $urandom_range(1, 3);
    case ($urandom_range(0, 3))
      0: rng = 22'h3fffff;
      1: rng = $urandom_range(0, 3000);
      2: rng = $urandom_range(2000, 9000);
      default: rng = $urandom_range(0, 200);
    endcase
    set_regs(hc, cc, rng);
    span = hc + cc + 1;
    if (with_clear) push_cmd(KIND_CLEAR, 0, 0, 0);
    n = $urandom_range(24, 36);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 15) push_cmd(KIND_EVAL, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 16383));
      else if (r < 20) push_cmd(KIND_ADD, $urandom_range(128, 255), $urandom_range(128, 255),
                                $urandom_range(0, 16383));
      else if (r < 22) push_cmd(KindSpare, $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 16383));
      else push_cmd(KIND_ADD, $urandom_range(0, span), $urandom_range(0, span),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                                : $urandom_range(0, 3000));
    end
    push_cmd(KIND_EVAL, 0, 0, 0);
    wait_idle();
  endtask

  initial begin
    foreach (link_len[i, j]) link_len[i][j] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // directed: houses 1..3, candidates 4 and 5
    set_regs(3, 2, 22'h3fffff);
    push_cmd(KIND_ADD, 4, 1, 5);
    push_cmd(KIND_ADD, 4, 2, 0);
    push_cmd(KIND_ADD, 4, 3, 16383);
    push_cmd(KIND_ADD, 5, 1, 7);
    push_cmd(KIND_ADD, 5, 2, 9);
    push_cmd(KIND_ADD, 2, 5, 3);   // shorter parallel edge replaces
    push_cmd(KIND_ADD, 5, 2, 8);   // longer one is dropped
    push_cmd(KIND_ADD, 5, 3, 1);
    push_cmd(KIND_ADD, 2, 2, 4);
    push_cmd(KIND_ADD, 255, 0, 1);
    push_cmd(KindSpare, 255, 255, 16383);
    push_cmd(KIND_EVAL, 0, 0, 0);
    wait_idle();
    set_regs(3, 2, 10);
    push_cmd(KIND_EVAL, 0, 0, 0);
    wait_idle();
    set_regs(0, 3, 0);             // no houses
    push_cmd(KIND_EVAL, 0, 0, 0);
    wait_idle();
    set_regs(239, 16, 0);
    push_cmd(KIND_EVAL, 0, 0, 0);
    wait_idle();
    set_regs(250, 20, 22'h3fffff); // candidates past the node range
    push_cmd(KIND_EVAL, 0, 0, 0);
    wait_idle();
    set_regs(3, 0, 22'h3fffff);
    push_cmd(KIND_EVAL, 0, 0, 0);
    wait_idle();

    for (int p = 0; p < 14; p++) random_phase(p % 4 == 0);

    repeat (20) @(posedge clk_i);
    $display("summary: %0d beats taken, %0d results checked (%0d with a station)",
             beats_in, picks_seen, picks_found);
    $display("covered: parallel and self edges, clears, no houses, oversize counts, ranges");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
